### design/array_stack_with_reverse_top_assert.svh
// Assertion macros shared by the stack design.
`ifndef ARRAY_STACK_WITH_REVERSE_TOP_ASSERT_SVH
`define ARRAY_STACK_WITH_REVERSE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asr assertion failed");

// Next-cycle implication, disabled during reset.
`define ASR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asr assertion failed");

`endif

### design/asr_pkg.sv
`timescale 1ns / 1ps
package asr_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = 7;
   localparam int CAP_W   = 7;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0] CAP_FALLBACK = CAP_W'(10);

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_PEEK    = 2'd2,
      OP_REVERSE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WR_PUSH,
      WR_LO,
      WR_HI
   } wsel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_SWAP_RD,
      S_SWAP_WR_LO,
      S_SWAP_WR_HI,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       mem_we;
      wsel_type   wsel;
      logic       rd_en;
      logic       rd_swap;
      logic       swap_init;
      logic       swap_step;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       load;
      logic       use_value;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   few;
      logic   pair_last;
   } stat_type;

   // Zero falls back to the default, anything above the array size clamps.
   function automatic logic [COUNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      logic [COUNT_W-1:0] res;
      if (cap == '0) begin
         res = COUNT_W'(CAP_FALLBACK);
      end else if (COUNT_W'(cap) > COUNT_W'(DEPTH)) begin
         res = COUNT_W'(DEPTH);
      end else begin
         res = COUNT_W'(cap);
      end
      return res;
   endfunction

endpackage

### design/asr_channels.sv
`timescale 1ns / 1ps
interface asr_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          func;
   logic signed [asr_pkg::DATA_W-1:0]   data;

   modport source (output valid, output func, output data, input ready);
   modport sink (input valid, input func, input data, output ready);
endinterface

interface asr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [asr_pkg::DATA_W-1:0]   value;
   logic [1:0]                          status;
   logic [asr_pkg::COUNT_W-1:0]         count;
   logic                                empty_res;
   logic                                full_res;

   modport source (output valid, output value, output status, output count,
                   output empty_res, output full_res, input ready);
   modport sink (input valid, input value, input status, input count,
                 input empty_res, input full_res, output ready);
endinterface

interface asr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [asr_pkg::CAP_W-1:0]           capacity;

   modport source (output valid, output capacity, input ready);
   modport sink (input valid, input capacity, output ready);
endinterface

### design/asr_dpath.sv
`timescale 1ns / 1ps
module asr_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  asr_pkg::cmd_type                    cmd,
   output asr_pkg::stat_type                   stat,
   input  logic [1:0]                          req_func,
   input  logic signed [asr_pkg::DATA_W-1:0]   req_data,
   input  logic                                csr_we,
   input  logic [asr_pkg::CAP_W-1:0]           csr_capacity,
   output logic signed [asr_pkg::DATA_W-1:0]   rsp_value,
   output logic [1:0]                          rsp_status,
   output logic [asr_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                rsp_empty_res,
   output logic                                rsp_full_res
);

   logic [asr_pkg::DATA_W-1:0]  mem [asr_pkg::DEPTH];

   asr_pkg::op_type             op_ff;
   logic [asr_pkg::DATA_W-1:0]  data_ff;
   logic [asr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [asr_pkg::CAP_W-1:0]   cap_ff;
   logic [asr_pkg::ADDR_W-1:0]  lo_ff, hi_ff;
   logic [asr_pkg::DATA_W-1:0]  rd_a_ff, rd_b_ff;

   logic [asr_pkg::DATA_W-1:0]  value_ff;
   asr_pkg::status_type         status_ff;
   logic [asr_pkg::COUNT_W-1:0] rcount_ff;
   logic                        empty_ff, full_ff;

   logic [asr_pkg::COUNT_W-1:0] cap_eff;
   logic [asr_pkg::COUNT_W-1:0] top_cnt;
   logic [asr_pkg::ADDR_W-1:0]  top_addr, raddr_a, waddr, span;
   logic [asr_pkg::DATA_W-1:0]  wdata;

   assign cap_eff  = asr_pkg::eff_cap(cap_ff);
   assign top_cnt  = count_ff - asr_pkg::COUNT_W'(1);
   assign top_addr = top_cnt[asr_pkg::ADDR_W-1:0];
   assign raddr_a  = cmd.rd_swap ? lo_ff : top_addr;
   assign span     = hi_ff - lo_ff;

   always_comb begin
      unique case (cmd.wsel)
         asr_pkg::WR_LO: begin
            waddr = lo_ff;
            wdata = rd_b_ff;
         end
         asr_pkg::WR_HI: begin
            waddr = hi_ff;
            wdata = rd_a_ff;
         end
         default: begin
            waddr = count_ff[asr_pkg::ADDR_W-1:0];
            wdata = data_ff;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + asr_pkg::COUNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = top_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= mem[raddr_a];
         rd_b_ff <= mem[hi_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= asr_pkg::CAP_FALLBACK;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            cap_ff <= csr_capacity;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= asr_pkg::op_type'(req_func);
         data_ff <= req_data;
      end
      // Walk the two indices toward each other, one pair per step.
      if (cmd.swap_init) begin
         lo_ff <= '0;
         hi_ff <= top_addr;
      end else if (cmd.swap_step) begin
         lo_ff <= lo_ff + asr_pkg::ADDR_W'(1);
         hi_ff <= hi_ff - asr_pkg::ADDR_W'(1);
      end
      if (cmd.load) begin
         value_ff  <= cmd.use_value ? rd_a_ff : '0;
         status_ff <= cmd.status;
         rcount_ff <= count_in;
         empty_ff  <= (count_in == '0);
         full_ff   <= (count_in >= cap_eff);
      end
   end

   assign stat.op        = op_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff >= cap_eff);
   assign stat.few       = (count_ff < asr_pkg::COUNT_W'(2));
   assign stat.pair_last = (span <= asr_pkg::ADDR_W'(2));

   assign rsp_value     = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_count     = rcount_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_full_res  = full_ff;

endmodule

### design/asr_ctrl.sv
`timescale 1ns / 1ps
module asr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  asr_pkg::stat_type  stat,
   output asr_pkg::cmd_type   cmd
);

   asr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == asr_pkg::S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.wsel = asr_pkg::WR_PUSH;
      unique case (state_ff)
         asr_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = asr_pkg::S_EXEC;
            end
         end
         asr_pkg::S_EXEC: begin
            // Hold until the result register can take a new item.
            if (out_free) begin
               unique case (stat.op)
                  asr_pkg::OP_PUSH: begin
                     cmd.load = 1'b1;
                     if (stat.full) begin
                        cmd.status = asr_pkg::ST_OVERFLOW;
                     end else begin
                        cmd.mem_we  = 1'b1;
                        cmd.cnt_inc = 1'b1;
                        cmd.status  = asr_pkg::ST_OK;
                     end
                     state_in = asr_pkg::S_IDLE;
                  end
                  asr_pkg::OP_POP, asr_pkg::OP_PEEK: begin
                     if (stat.empty) begin
                        cmd.load   = 1'b1;
                        cmd.status = asr_pkg::ST_UNDERFLOW;
                        state_in   = asr_pkg::S_IDLE;
                     end else begin
                        cmd.rd_en = 1'b1;
                        state_in  = asr_pkg::S_READ;
                     end
                  end
                  default: begin
                     if (stat.few) begin
                        cmd.load   = 1'b1;
                        cmd.status = asr_pkg::ST_OK;
                        state_in   = asr_pkg::S_IDLE;
                     end else begin
                        cmd.swap_init = 1'b1;
                        state_in      = asr_pkg::S_SWAP_RD;
                     end
                  end
               endcase
            end
         end
         asr_pkg::S_READ: begin
            if (out_free) begin
               cmd.load      = 1'b1;
               cmd.use_value = 1'b1;
               cmd.status    = asr_pkg::ST_OK;
               cmd.cnt_dec   = (stat.op == asr_pkg::OP_POP);
               state_in      = asr_pkg::S_IDLE;
            end
         end
         asr_pkg::S_SWAP_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_swap = 1'b1;
            state_in    = asr_pkg::S_SWAP_WR_LO;
         end
         asr_pkg::S_SWAP_WR_LO: begin
            cmd.mem_we = 1'b1;
            cmd.wsel   = asr_pkg::WR_LO;
            state_in   = asr_pkg::S_SWAP_WR_HI;
         end
         asr_pkg::S_SWAP_WR_HI: begin
            cmd.mem_we    = 1'b1;
            cmd.wsel      = asr_pkg::WR_HI;
            cmd.swap_step = 1'b1;
            state_in      = stat.pair_last ? asr_pkg::S_FINISH : asr_pkg::S_SWAP_RD;
         end
         asr_pkg::S_FINISH: begin
            if (out_free) begin
               cmd.load   = 1'b1;
               cmd.status = asr_pkg::ST_OK;
               state_in   = asr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = asr_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

### design/array_stack_with_reverse_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// req_ch    in         func, data
// rsp_ch    out        value, status, count, empty_res, full_res
// csr_ch    in         capacity (ready whenever out of reset)
//
// One item at a time. Push, overflow and underflow resolve in S_EXEC; pop and
// peek add S_READ, set by the registered read of the stack memory. Reverse of
// fewer than two words ends in S_EXEC; otherwise it swaps floor(count / 2)
// pairs, one read and two writes each on the single write port, then S_FINISH.
// Reset clears the count and sets capacity to 10; the memory is not cleared.
// A result waits in its output register while rsp_ch stalls; the next item is
// accepted but held before execution until that register frees.
`include "array_stack_with_reverse_top_assert.svh"
module array_stack_with_reverse_top (
   input  logic       clock,
   input  logic       reset,
   asr_req_if.sink    req_ch,
   asr_rsp_if.source  rsp_ch,
   asr_csr_if.sink    csr_ch
);

   asr_pkg::cmd_type  cmd;
   asr_pkg::stat_type stat;

   assign csr_ch.ready = !reset;

   asr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   asr_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_func      (req_ch.func),
      .req_data      (req_ch.data),
      .csr_we        (csr_ch.valid),
      .csr_capacity  (csr_ch.capacity),
      .rsp_value     (rsp_ch.value),
      .rsp_status    (rsp_ch.status),
      .rsp_count     (rsp_ch.count),
      .rsp_empty_res (rsp_ch.empty_res),
      .rsp_full_res  (rsp_ch.full_res)
   );

   `ASR_ASSERT_NEXT(a_one_item, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `ASR_ASSERT_IMPL(a_count_range, clock, reset, rsp_ch.valid,
                    rsp_ch.count <= asr_pkg::COUNT_W'(asr_pkg::DEPTH))
   `ASR_ASSERT_IMPL(a_empty_flag, clock, reset, rsp_ch.valid, rsp_ch.empty_res == (rsp_ch.count == '0))
   `ASR_ASSERT_IMPL(a_err_no_value, clock, reset,
                    rsp_ch.valid && rsp_ch.status != asr_pkg::ST_OK, rsp_ch.value == '0)

endmodule
